// ===== rtl/salr_pkg.sv =====
// salr_pkg: shared constants and controller/datapath handshake types
// for the skewed-associative lru replacement unit
// no dependencies
`default_nettype none

package salr_pkg;

    // default geometry
    localparam int WAYS_DEFAULT     = 4;
    localparam int SET_BITS_DEFAULT = 10;

    // fixed field widths of the request and response words
    localparam int ADDR_W    = 48;
    localparam int WAY_W     = 4;
    localparam int SET_IDX_W = 10;
    localparam int AGE_W     = 32;
    localparam int BOFF_W    = 4;

    // block offset register reset value
    localparam logic [BOFF_W-1:0] BOFF_RESET = 4'd6;

    // request op codes
    localparam logic OP_REPLACE = 1'b0;
    localparam logic OP_TOUCH   = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic clear;    // write zero at the sweep address
        logic load;     // capture a request word
        logic scan_rd;  // read the timestamp of the current scan way
        logic finish;   // stamp the chosen entry and emit the response
    } ctrl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic clear_last;  // sweep address is at the last entry
        logic scan_last;   // scan way is the last way
        logic out_free;    // response register can take a new word
    } ctrl_sts_t;

endpackage

`default_nettype wire

// ===== rtl/salr_req_if.sv =====
// salr_req_if: request channel (valid/ready plus op, address, hit way)
// depends on salr_pkg for field widths
`default_nettype none

interface salr_req_if;
    logic                           valid;
    logic                           ready;
    logic                           op;
    logic [salr_pkg::ADDR_W-1:0]    address;
    logic [salr_pkg::WAY_W-1:0]     hit_way;

    modport source (output valid, output op, output address, output hit_way, input ready);
    modport sink   (input valid, input op, input address, input hit_way, output ready);
endinterface

`default_nettype wire

// ===== rtl/salr_rsp_if.sv =====
// salr_rsp_if: response channel (valid/ready plus way, set index, victim age)
// depends on salr_pkg for field widths
`default_nettype none

interface salr_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [salr_pkg::WAY_W-1:0]         way;
    logic [salr_pkg::SET_IDX_W-1:0]     set_index;
    logic [salr_pkg::AGE_W-1:0]         victim_age;

    modport source (output valid, output way, output set_index, output victim_age, input ready);
    modport sink   (input valid, input way, input set_index, input victim_age, output ready);
endinterface

`default_nettype wire

// ===== rtl/salr_ram.sv =====
// salr_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module salr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/salr_ctrl.sv =====
// salr_ctrl: sequencer for clearing, victim scan and stamping
// depends on salr_pkg for command and status types
`default_nettype none

module salr_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_op,
    output      logic                in_ready,
    output      salr_pkg::ctrl_cmd_t cmd,
    input  wire salr_pkg::ctrl_sts_t sts
);

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_CLEAR  = 3'd0;
    localparam logic [ST_W-1:0] ST_IDLE   = 3'd1;
    localparam logic [ST_W-1:0] ST_SCAN   = 3'd2;
    localparam logic [ST_W-1:0] ST_CMP    = 3'd3;
    localparam logic [ST_W-1:0] ST_FINISH = 3'd4;

    logic [ST_W-1:0] state_reg;
    logic [ST_W-1:0] state_next;

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (in_op == salr_pkg::OP_TOUCH) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                // last timestamp is compared in this cycle
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/salr_dp.sv =====
// salr_dp: set index hashing, timestamp ram, age compare, access counter
// and response register
// depends on salr_pkg, salr_rsp_if and salr_ram
`default_nettype none

module salr_dp #(
    parameter int WAYS     = salr_pkg::WAYS_DEFAULT,
    parameter int SET_BITS = salr_pkg::SET_BITS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [salr_pkg::BOFF_W-1:0]   cfg_wr_data,
    input  wire logic                          req_op,
    input  wire logic [salr_pkg::ADDR_W-1:0]   req_address,
    input  wire logic [salr_pkg::WAY_W-1:0]    req_hit_way,
    input  wire salr_pkg::ctrl_cmd_t           cmd,
    output      salr_pkg::ctrl_sts_t           sts,
    salr_rsp_if.source                         rsp
);

    localparam int WAY_BITS = $clog2(WAYS);
    localparam int AW       = SET_BITS + WAY_BITS;
    localparam int DEPTH    = 1 << AW;
    localparam int AGE_W    = salr_pkg::AGE_W;
    localparam int WAY_W    = salr_pkg::WAY_W;
    localparam int IDX_W    = salr_pkg::SET_IDX_W;
    // rotation amounts of each bit of the way number, within the set width
    localparam int ROT_1    = 1 % SET_BITS;
    localparam int ROT_2    = 2 % SET_BITS;
    localparam int ROT_4    = 4 % SET_BITS;
    localparam int ROT_8    = 8 % SET_BITS;

    // rotate left by a fixed amount below SET_BITS
    function automatic logic [SET_BITS-1:0] rotl_const(logic [SET_BITS-1:0] v, int r);
        logic [2*SET_BITS-1:0] d;
        d = {v, v} << r;
        return d[2*SET_BITS-1:SET_BITS];
    endfunction

    // rotate left by a way number, modulo SET_BITS, one stage per amount bit
    function automatic logic [SET_BITS-1:0] rotl_way(logic [SET_BITS-1:0] v,
                                                     logic [WAY_W-1:0] amt);
        logic [SET_BITS-1:0] t;
        t = v;
        if (amt[0]) t = rotl_const(t, ROT_1);
        if (amt[1]) t = rotl_const(t, ROT_2);
        if (amt[2]) t = rotl_const(t, ROT_4);
        if (amt[3]) t = rotl_const(t, ROT_8);
        return t;
    endfunction

    logic [salr_pkg::BOFF_W-1:0] boff_reg;
    logic [AW-1:0]               clr_addr_reg;
    logic [AGE_W-1:0]            counter_reg;
    logic                        op_reg;
    logic [WAY_W-1:0]            hit_way_reg;
    logic [SET_BITS-1:0]         a1_reg;
    logic [SET_BITS-1:0]         a2_reg;
    logic [WAY_BITS-1:0]         scan_way_reg;
    logic                        rd_pend_reg;
    logic [WAY_BITS-1:0]         rd_way_reg;
    logic [SET_BITS-1:0]         rd_set_reg;
    logic                        first_reg;
    logic [AGE_W-1:0]            best_age_reg;
    logic [WAY_BITS-1:0]         best_way_reg;
    logic [SET_BITS-1:0]         best_set_reg;
    logic                        rsp_valid_reg;
    logic [WAY_W-1:0]            rsp_way_reg;
    logic [IDX_W-1:0]            rsp_set_reg;
    logic [AGE_W-1:0]            rsp_age_reg;

    logic [salr_pkg::ADDR_W-1:0] line;
    logic [SET_BITS-1:0]         scan_set;
    logic [AGE_W-1:0]            ram_rdata;
    logic [AGE_W-1:0]            age;
    logic                        hit_ok;
    logic                        stamp_en;
    logic [WAY_W-1:0]            chosen_way;
    logic [SET_BITS-1:0]         chosen_set;
    logic [SET_BITS+IDX_W-1:0]   set_ext;
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [AGE_W-1:0]            ram_wdata;

    // block offset register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boff_reg <= salr_pkg::BOFF_RESET;
        end
        else if (cfg_wr_en)
        begin
            boff_reg <= cfg_wr_data;
        end
    end

    // drop the block offset and split the two index fields
    assign line = req_address >> boff_reg;

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= req_op;
            hit_way_reg <= req_hit_way;
            a1_reg      <= line[SET_BITS-1:0];
            a2_reg      <= line[2*SET_BITS-1:SET_BITS];
        end
    end

    // clear sweep address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // scan way counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_way_reg <= '0;
        end
        else if (cmd.load)
        begin
            scan_way_reg <= '0;
        end
        else if (cmd.scan_rd)
        begin
            scan_way_reg <= scan_way_reg + 1'b1;
        end
    end

    assign scan_set = a2_reg ^ rotl_way(a1_reg, WAY_W'(scan_way_reg));

    // read tag pipeline, aligned with the registered ram data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= cmd.scan_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_rd)
        begin
            rd_way_reg <= scan_way_reg;
            rd_set_reg <= scan_set;
        end
    end

    // oldest entry tracking, later way wins a tie
    assign age = counter_reg - ram_rdata;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            first_reg <= 1'b1;
        end
        else if (rd_pend_reg)
        begin
            first_reg <= 1'b0;
            if (first_reg || (best_age_reg <= age))
            begin
                best_age_reg <= age;
                best_way_reg <= rd_way_reg;
                best_set_reg <= rd_set_reg;
            end
        end
    end

    // chosen entry and stamp enable
    assign hit_ok     = {1'b0, hit_way_reg} < (WAY_W + 1)'(WAYS);
    assign chosen_way = (op_reg == salr_pkg::OP_TOUCH) ? hit_way_reg : WAY_W'(best_way_reg);
    assign chosen_set = (op_reg == salr_pkg::OP_TOUCH) ? (a2_reg ^ rotl_way(a1_reg, hit_way_reg))
                                                       : best_set_reg;
    assign stamp_en   = cmd.finish && ((op_reg == salr_pkg::OP_REPLACE) || hit_ok);
    assign set_ext    = {{IDX_W{1'b0}}, chosen_set};

    // access counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
        end
        else if (stamp_en)
        begin
            counter_reg <= counter_reg + 1'b1;
        end
    end

    // timestamp ram write port: clear sweep or stamp
    assign ram_we    = cmd.clear || stamp_en;
    assign ram_waddr = cmd.clear ? clr_addr_reg : {chosen_set, chosen_way[WAY_BITS-1:0]};
    assign ram_wdata = cmd.clear ? '0 : counter_reg;

    salr_ram #(
        .WIDTH (AGE_W),
        .DEPTH (DEPTH)
    ) u_ts_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.scan_rd),
        .raddr ({scan_set, scan_way_reg}),
        .rdata (ram_rdata)
    );

    // response word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            rsp_way_reg <= chosen_way;
            rsp_set_reg <= set_ext[IDX_W-1:0];
            rsp_age_reg <= (op_reg == salr_pkg::OP_TOUCH) ? '0 : best_age_reg;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.way        = rsp_way_reg;
    assign rsp.set_index  = rsp_set_reg;
    assign rsp.victim_age = rsp_age_reg;

    // status to controller
    assign sts.clear_last = &clr_addr_reg;
    assign sts.scan_last  = (scan_way_reg == WAY_BITS'(WAYS - 1));
    assign sts.out_free   = !rsp_valid_reg || rsp.ready;

endmodule

`default_nettype wire

// ===== rtl/skewed_assoc_lru_replacement_unit.sv =====
// Skewed-associative cache LRU replacement unit.
//
// Request channel req (valid/ready): op, byte address, hit way. A replace
// word (op 0) scans the skewed set of every way and returns the way whose
// timestamp is oldest against the global access counter, later way on a tie.
// A touch word (op 1) echoes the hit way and its skewed set index. Both stamp
// the chosen entry with the counter and advance it; a touch of a way beyond
// WAYS writes nothing. One response word on rsp (valid/ready) per request.
// cfg_wr_en / cfg_wr_data write the block offset register (reset 6).
//
// Sequence: a replace reads the timestamp of each way in turn, paced by the
// single read port of the timestamp ram (one way read per cycle), then does
// the final compare and the stamping write; a touch goes straight to stamping.
// The response is registered and shows in the cycle after the stamping cycle.
// A new request is taken while a response still waits; if rsp stalls, the
// next item holds in its stamping step until the response register frees.
// After reset the timestamp ram is zeroed by a sweep over all
// 2^(SET_BITS + clog2(WAYS)) entries, during which req.ready stays low.
// Depends on salr_pkg, salr_req_if, salr_rsp_if, salr_ctrl, salr_dp.
`default_nettype none

module skewed_assoc_lru_replacement_unit #(
    parameter int WAYS     = salr_pkg::WAYS_DEFAULT,
    parameter int SET_BITS = salr_pkg::SET_BITS_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [salr_pkg::BOFF_W-1:0] cfg_wr_data,
    salr_req_if.sink                         req,
    salr_rsp_if.source                       rsp
);

    salr_pkg::ctrl_cmd_t cmd;
    salr_pkg::ctrl_sts_t sts;
    logic                in_ready;

    assign req.ready = in_ready;

    // sequencer
    salr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_op    (req.op),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // datapath
    salr_dp #(
        .WAYS     (WAYS),
        .SET_BITS (SET_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_op      (req.op),
        .req_address (req.address),
        .req_hit_way (req.hit_way),
        .cmd         (cmd),
        .sts         (sts),
        .rsp         (rsp)
    );

endmodule

`default_nettype wire
